// ===== hdl/rwa_pkg.sv =====
package rwa_pkg;

	localparam int VALUE_W   = 16;
	localparam int SPAN_W    = VALUE_W + 1;
	localparam int RAW_W     = 2 * VALUE_W + 2;
	localparam int DEN_W     = VALUE_W + 2;
	localparam int SHAMT_W   = $clog2(VALUE_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);

	localparam logic signed [VALUE_W-1:0] RANGE_LOW_RST  = VALUE_W'(0);
	localparam logic signed [VALUE_W-1:0] RANGE_HIGH_RST = VALUE_W'(255);

	typedef enum logic [3:0] {
		OP_LOAD  = 4'd0,
		OP_INC   = 4'd1,
		OP_DEC   = 4'd2,
		OP_ADD   = 4'd3,
		OP_SUB   = 4'd4,
		OP_MUL   = 4'd5,
		OP_REM   = 4'd6,
		OP_XOR   = 4'd7,
		OP_OR    = 4'd8,
		OP_AND   = 4'd9,
		OP_SHL   = 4'd10,
		OP_SHR   = 4'd11,
		OP_NOT   = 4'd12,
		OP_NEG   = 4'd13,
		OP_EXACT = 4'd14,
		OP_SOLVE = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_ZERO_DIV    = 3'd1,
		ST_INEXACT     = 3'd2,
		ST_NO_SOLUTION = 3'd3,
		ST_BAD_SHIFT   = 3'd4
	} status_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  operand;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  value;
		status_t                    status;
	} rsp_t;

	typedef enum logic [1:0] {
		DSEL_TRUNC = 2'd0,
		DSEL_WRAP  = 2'd1,
		DSEL_OPD   = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic      load_in;
		logic      exec;
		logic      div_start;
		div_sel_t  div_sel;
		logic      take_trunc;
		logic      take_wrap;
		logic      take_a;
		logic      walk;
		logic      emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic  err;
		logic  is_divop;
		logic  is_solve;
		logic  div_done;
		logic  inexact;
		logic  found;
		logic  walk_end;
		logic  out_free;
	} dp_stat_t;

endpackage

// ===== hdl/rwa_div.sv =====
module rwa_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [rwa_pkg::RAW_W-1:0]     dividend,
	input  logic signed [rwa_pkg::DEN_W-1:0]     divisor,
	output logic                                 done,
	output logic signed [rwa_pkg::RAW_W:0]       quo,
	output logic signed [rwa_pkg::DEN_W-1:0]     rem
);

	localparam int R     = rwa_pkg::RAW_W;
	localparam int D     = rwa_pkg::DEN_W;
	localparam int CNT_W = $clog2(R + 1);

	logic [R-1:0]     num_q;
	logic [D-1:0]     den_q;
	logic [D-1:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             qneg_q;
	logic             rneg_q;

	logic [D-1:0] sh;
	logic [D:0]   diff;
	logic         fits;
	logic [R-1:0] num_mag;
	logic [D-1:0] den_mag;

	// Restoring division on magnitudes, one quotient bit per cycle.
	assign sh      = {rem_q[D-2:0], num_q[R-1]};
	assign diff    = {1'b0, sh} - {1'b0, den_q};
	assign fits    = !diff[D];
	assign num_mag = dividend[R-1] ? (~dividend + 1'b1) : dividend;
	assign den_mag = divisor[D-1] ? (~divisor + 1'b1) : divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(R);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num_mag;
			den_q  <= den_mag;
			rem_q  <= '0;
			qneg_q <= dividend[R-1] ^ divisor[D-1];
			rneg_q <= dividend[R-1];
		end else if (busy_q) begin
			num_q <= {num_q[R-2:0], fits};
			rem_q <= fits ? diff[D-1:0] : sh;
		end
	end

	assign done = done_q;
	assign quo  = qneg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
	assign rem  = rneg_q ? -$signed(rem_q) : $signed(rem_q);

endmodule

// ===== hdl/rwa_dp.sv =====
module rwa_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [rwa_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [rwa_pkg::VALUE_W-1:0]            cfg_data,
	input  rwa_pkg::cmd_t                          cmd,
	output rwa_pkg::rsp_t                          rsp,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	input  rwa_pkg::ctl_cmd_t                      ctl,
	output rwa_pkg::dp_stat_t                      stat
);

	localparam int W  = rwa_pkg::VALUE_W;
	localparam int SW = rwa_pkg::SPAN_W;
	localparam int R  = rwa_pkg::RAW_W;
	localparam int D  = rwa_pkg::DEN_W;

	logic signed [W-1:0]  low_q;
	logic signed [W-1:0]  high_q;
	logic signed [W-1:0]  acc_q;
	rwa_pkg::op_t         op_q;
	logic signed [W-1:0]  opd_q;
	logic signed [R-1:0]  raw_q;
	rwa_pkg::status_t     st_q;
	logic [SW-1:0]        a_q;
	logic [SW-1:0]        y_q;
	logic [SW-1:0]        y0_q;
	logic [SW-1:0]        k_q;
	rwa_pkg::rsp_t        rsp_q;
	logic                 rsp_valid_q;

	logic signed [W:0]    diff;
	logic [SW-1:0]        span;
	logic signed [W:0]    t;
	logic                 t_in;
	logic                 opd_zero;
	logic                 bad_shift;
	rwa_pkg::status_t     est;
	logic signed [W-1:0]  mul_a;
	logic signed [2*W-1:0] prod;
	logic signed [R-1:0]  a_x;
	logic signed [R-1:0]  b_x;
	logic signed [R-1:0]  low_x;
	logic [rwa_pkg::SHAMT_W-1:0] shamt;
	logic signed [R-1:0]  raw;
	logic signed [R-1:0]  dvd;
	logic signed [D-1:0]  dvs;
	logic signed [D-1:0]  span_s;
	logic                 div_done;
	logic signed [R:0]    quo;
	logic signed [D-1:0]  rem;
	logic signed [D-1:0]  fm_full;
	logic [SW-1:0]        fm;
	logic [SW:0]          ysum;
	logic [SW:0]          ysub;
	logic [SW-1:0]        ynext;
	logic                 found;

	assign diff   = $signed({high_q[W-1], high_q}) - $signed({low_q[W-1], low_q});
	assign span   = diff[W] ? SW'(1) : (diff[W:0] + SW'(1));
	assign span_s = $signed({1'b0, span});
	assign t      = $signed({acc_q[W-1], acc_q}) - $signed({low_q[W-1], low_q});
	assign t_in   = !t[W] && (t[W:0] < span);

	assign opd_zero  = (opd_q == '0);
	assign bad_shift = opd_q[W-1] || ($unsigned(opd_q) >= W'(W));

	always_comb begin
		case (op_q)
			rwa_pkg::OP_REM, rwa_pkg::OP_EXACT:
				est = opd_zero ? rwa_pkg::ST_ZERO_DIV : rwa_pkg::ST_OK;
			rwa_pkg::OP_SOLVE:
				est = opd_zero ? rwa_pkg::ST_ZERO_DIV :
				      (t_in ? rwa_pkg::ST_OK : rwa_pkg::ST_NO_SOLUTION);
			rwa_pkg::OP_SHL, rwa_pkg::OP_SHR:
				est = bad_shift ? rwa_pkg::ST_BAD_SHIFT : rwa_pkg::ST_OK;
			default:
				est = rwa_pkg::ST_OK;
		endcase
	end

	assign mul_a = (op_q == rwa_pkg::OP_SOLVE) ? low_q : acc_q;
	assign prod  = mul_a * opd_q;
	assign a_x   = R'(acc_q);
	assign b_x   = R'(opd_q);
	assign low_x = R'(low_q);
	assign shamt = opd_q[rwa_pkg::SHAMT_W-1:0];

	always_comb begin
		case (op_q)
			rwa_pkg::OP_LOAD:  raw = b_x;
			rwa_pkg::OP_INC:   raw = a_x + R'(1);
			rwa_pkg::OP_DEC:   raw = a_x - R'(1);
			rwa_pkg::OP_ADD:   raw = a_x + b_x;
			rwa_pkg::OP_SUB:   raw = a_x - b_x;
			rwa_pkg::OP_MUL:   raw = R'(prod);
			rwa_pkg::OP_XOR:   raw = R'(acc_q ^ opd_q);
			rwa_pkg::OP_OR:    raw = R'(acc_q | opd_q);
			rwa_pkg::OP_AND:   raw = R'(acc_q & opd_q);
			rwa_pkg::OP_SHL:   raw = a_x <<< shamt;
			rwa_pkg::OP_SHR:   raw = R'(acc_q >>> shamt);
			rwa_pkg::OP_NOT:   raw = ~a_x;
			rwa_pkg::OP_NEG:   raw = -a_x;
			rwa_pkg::OP_SOLVE: raw = R'(prod);
			default:           raw = a_x;
		endcase
	end

	always_comb begin
		case (ctl.div_sel)
			rwa_pkg::DSEL_TRUNC: begin
				dvd = a_x;
				dvs = D'(opd_q);
			end
			rwa_pkg::DSEL_WRAP: begin
				dvd = raw_q - low_x;
				dvs = span_s;
			end
			default: begin
				dvd = b_x;
				dvs = span_s;
			end
		endcase
	end

	rwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	// Floored remainder against the positive span.
	assign fm_full = rem[D-1] ? (rem + span_s) : rem;
	assign fm      = fm_full[SW-1:0];

	// Solve walk: y tracks (range_low + k) * operand - range_low modulo span.
	assign ysum  = {1'b0, y_q} + {1'b0, a_q};
	assign ysub  = ysum - {1'b0, span};
	assign ynext = (ysum >= {1'b0, span}) ? ysub[SW-1:0] : ysum[SW-1:0];
	assign found = (y_q == t[W:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= rwa_pkg::RANGE_LOW_RST;
			high_q      <= rwa_pkg::RANGE_HIGH_RST;
			acc_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == rwa_pkg::REG_RANGE_LOW) begin
					low_q <= cfg_data;
				end else if (cfg_index == rwa_pkg::REG_RANGE_HIGH) begin
					high_q <= cfg_data;
				end
			end
			if (ctl.take_wrap && (op_q != rwa_pkg::OP_SOLVE)) begin
				acc_q <= low_q + $signed(fm[W-1:0]);
			end else if (ctl.walk && found) begin
				acc_q <= low_q + $signed(k_q[W-1:0]);
			end
			if (ctl.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			op_q  <= cmd.op;
			opd_q <= cmd.operand;
		end
		if (ctl.exec) begin
			raw_q <= raw;
			st_q  <= est;
		end
		if (ctl.take_trunc) begin
			if (op_q == rwa_pkg::OP_REM) begin
				raw_q <= R'(rem);
			end else begin
				raw_q <= quo[R-1:0];
			end
			if (stat.inexact) begin
				st_q <= rwa_pkg::ST_INEXACT;
			end
		end
		if (ctl.take_a) begin
			a_q <= fm;
		end
		if (ctl.take_wrap && (op_q == rwa_pkg::OP_SOLVE)) begin
			y_q  <= fm;
			y0_q <= fm;
			k_q  <= '0;
		end
		if (ctl.walk && !found) begin
			y_q <= ynext;
			k_q <= k_q + 1'b1;
			if (stat.walk_end) begin
				st_q <= rwa_pkg::ST_NO_SOLUTION;
			end
		end
		if (ctl.emit) begin
			rsp_q.value  <= acc_q;
			rsp_q.status <= st_q;
		end
	end

	assign stat.err      = (est != rwa_pkg::ST_OK);
	assign stat.is_divop = (op_q inside {rwa_pkg::OP_REM, rwa_pkg::OP_EXACT});
	assign stat.is_solve = (op_q == rwa_pkg::OP_SOLVE);
	assign stat.div_done = div_done;
	assign stat.inexact  = (op_q == rwa_pkg::OP_EXACT) && (rem != '0);
	assign stat.found    = found;
	assign stat.walk_end = !found && (ynext == y0_q);
	assign stat.out_free = !rsp_valid_q || !rsp_stall;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== hdl/rwa_ctrl.sv =====
module rwa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  rwa_pkg::dp_stat_t   stat,
	output rwa_pkg::ctl_cmd_t   ctl
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_EXEC  = 9'b000000010,
		S_DIVT  = 9'b000000100,
		S_WRAP0 = 9'b000001000,
		S_WRAPW = 9'b000010000,
		S_SOLA  = 9'b000100000,
		S_WALK  = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_SPARE = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctl.div_sel = rwa_pkg::DSEL_WRAP;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.err) begin
					state_d = S_FIN;
				end else if (stat.is_divop) begin
					ctl.div_start = 1'b1;
					ctl.div_sel   = rwa_pkg::DSEL_TRUNC;
					state_d       = S_DIVT;
				end else if (stat.is_solve) begin
					ctl.div_start = 1'b1;
					ctl.div_sel   = rwa_pkg::DSEL_OPD;
					state_d       = S_SOLA;
				end else begin
					state_d = S_WRAP0;
				end
			end
			S_DIVT: begin
				if (stat.div_done) begin
					ctl.take_trunc = 1'b1;
					state_d        = stat.inexact ? S_FIN : S_WRAP0;
				end
			end
			S_SOLA: begin
				if (stat.div_done) begin
					ctl.take_a = 1'b1;
					state_d    = S_WRAP0;
				end
			end
			S_WRAP0: begin
				ctl.div_start = 1'b1;
				state_d       = S_WRAPW;
			end
			S_WRAPW: begin
				if (stat.div_done) begin
					ctl.take_wrap = 1'b1;
					state_d       = stat.is_solve ? S_WALK : S_FIN;
				end
			end
			S_WALK: begin
				ctl.walk = 1'b1;
				if (stat.found || stat.walk_end) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);

endmodule

// ===== hdl/range_wrap_alu.sv =====
// Wraparound range accumulator. Each command transfer on the cmd channel applies
// one operation to the accumulator and always yields exactly one response
// transfer on the rsp channel carrying the new accumulator value and a status.
// The cfg channel writes range_low (index 0) and range_high (index 1); cfg_ready
// is always high, and writes are meant to happen only while the block is idle.
// One command is processed at a time. A simple operation passes through the
// bit-serial divider once, which reduces the raw result into the range, and the
// next command can be accepted in the same cycle that its response is presented.
// Remainder and exact divide pass through the divider twice (an inexact exact
// divide stops after the first pass). Solve divide uses the divider twice and
// then walks candidates one per cycle until one matches or the walk wraps around.
// Errors skip the divider and respond with the value kept.
// The response sits in an output register, so a finished result may wait on
// rsp_stall while the next command is accepted and computed; the block only
// holds in its final state if the previous response is still stalled.
// Reset clears the accumulator to zero and the range to 0..255.
module range_wrap_alu (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  rwa_pkg::cmd_t                      cmd,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output rwa_pkg::rsp_t                      rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rwa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rwa_pkg::VALUE_W-1:0]        cfg_data
);

	rwa_pkg::ctl_cmd_t ctl;
	rwa_pkg::dp_stat_t stat;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	// The controller sequences each command through the shared divider.
	rwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// The datapath holds the range registers, accumulator and response register.
	rwa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule
